FILE: hw/rtl/srbf_pkg.sv
`default_nettype none

package srbf_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RA_START  = 3'd0,
        CFG_RA_END    = 3'd1,
        CFG_RA_WRAPS  = 3'd2,
        CFG_SPD_START = 3'd3,
        CFG_SPD_END   = 3'd4,
        CFG_MAG_LOW   = 3'd5,
        CFG_MAG_HIGH  = 3'd6,
        CFG_ZONE_ID   = 3'd7
    } t_cfg_idx;

    localparam logic [26:0] RA_END_RST   = 27'd129600000;
    localparam logic [25:0] SPD_END_RST  = 26'd64800000;
    localparam logic [9:0]  MAG_NONE     = 10'd999;
    localparam logic [9:0]  MAG_HIGH_RST = 10'd999;

    // floor(x / 1000) == (x * DIV_MUL) >> DIV_SHIFT for every 32-bit x.
    localparam logic [28:0] DIV_MUL   = 29'd274877907;
    localparam int unsigned DIV_SHIFT = 38;

    typedef struct packed {
        logic [26:0] ra_start;
        logic [26:0] ra_end;
        logic        ra_wraps;
        logic [25:0] spd_start;
        logic [25:0] spd_end;
        logic [9:0]  mag_low;
        logic [9:0]  mag_high;
        logic [10:0] zone_id;
    } t_cfg;

    typedef struct packed {
        logic [31:0] ra_u;
        logic [31:0] spd_u;
        logic [31:0] recno;
        logic        neg;
        logic        win_ok;
    } t_pass;

    typedef struct packed {
        t_pass       pass;
        logic [31:0] mabs;
    } t_front;

    typedef struct packed {
        t_pass       pass;
        logic [9:0]  rrr;
        logic [9:0]  bbb;
        logic [9:0]  fff;
        logic [3:0]  qd;
    } t_digit;

endpackage

`default_nettype wire

FILE: hw/rtl/srbf_in_if.sv
`default_nettype none

interface srbf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] ra_word;
    logic [31:0] spd_word;
    logic [31:0] mag_word;
    logic [31:0] record_number;

    modport source (output valid, ra_word, spd_word, mag_word, record_number, input ready);
    modport sink   (input valid, ra_word, spd_word, mag_word, record_number, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srbf_out_if.sv
`default_nettype none

interface srbf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ra_cas;
    logic signed [31:0] spd_cas;
    logic        [9:0]  red_mag;
    logic        [9:0]  blue_mag;
    logic               act_match;
    logic        [3:0]  quality_flag;
    logic        [9:0]  plate_field;
    logic        [31:0] star_position;
    logic        [10:0] star_zone;

    modport source (
        output valid, ra_cas, spd_cas, red_mag, blue_mag, act_match, quality_flag,
               plate_field, star_position, star_zone,
        input  ready
    );
    modport sink (
        input  valid, ra_cas, spd_cas, red_mag, blue_mag, act_match, quality_flag,
               plate_field, star_position, star_zone,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/srbf_cfg_if.sv
`default_nettype none

interface srbf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [srbf_pkg::CFG_IDX_W-1:0]   index;
    logic [31:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srbf_cfg.sv
`default_nettype none

module srbf_cfg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    srbf_cfg_if.sink        i_cfg,
    output srbf_pkg::t_cfg  o_cfg
);

    srbf_pkg::t_cfg r_cfg;
    srbf_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (srbf_pkg::t_cfg_idx'(i_cfg.index))
                srbf_pkg::CFG_RA_START:  n_cfg.ra_start  = i_cfg.data[26:0];
                srbf_pkg::CFG_RA_END:    n_cfg.ra_end    = i_cfg.data[26:0];
                srbf_pkg::CFG_RA_WRAPS:  n_cfg.ra_wraps  = i_cfg.data[0];
                srbf_pkg::CFG_SPD_START: n_cfg.spd_start = i_cfg.data[25:0];
                srbf_pkg::CFG_SPD_END:   n_cfg.spd_end   = i_cfg.data[25:0];
                srbf_pkg::CFG_MAG_LOW:   n_cfg.mag_low   = i_cfg.data[9:0];
                srbf_pkg::CFG_MAG_HIGH:  n_cfg.mag_high  = i_cfg.data[9:0];
                srbf_pkg::CFG_ZONE_ID:   n_cfg.zone_id   = i_cfg.data[10:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ra_start  <= 27'd0;
            r_cfg.ra_end    <= srbf_pkg::RA_END_RST;
            r_cfg.ra_wraps  <= 1'b0;
            r_cfg.spd_start <= 26'd0;
            r_cfg.spd_end   <= srbf_pkg::SPD_END_RST;
            r_cfg.mag_low   <= 10'd0;
            r_cfg.mag_high  <= srbf_pkg::MAG_HIGH_RST;
            r_cfg.zone_id   <= 11'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/srbf_front.sv
`default_nettype none

module srbf_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire srbf_pkg::t_cfg   i_cfg,
    srbf_in_if.sink               i_in,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output srbf_pkg::t_front      o_front
);

    logic             r_valid;
    srbf_pkg::t_front r_front;
    srbf_pkg::t_front n_front;
    logic             w_ready;
    logic             w_ra_ge;
    logic             w_ra_le;
    logic             w_spd_ok;
    logic [31:0]      w_mag_u;

    assign w_ready    = !r_valid || i_ready;
    assign i_in.ready = w_ready;
    assign o_valid    = r_valid;
    assign o_front    = r_front;

    always_comb begin
        n_front.pass.ra_u  = {i_in.ra_word[7:0], i_in.ra_word[15:8],
                              i_in.ra_word[23:16], i_in.ra_word[31:24]};
        n_front.pass.spd_u = {i_in.spd_word[7:0], i_in.spd_word[15:8],
                              i_in.spd_word[23:16], i_in.spd_word[31:24]};
        w_mag_u            = {i_in.mag_word[7:0], i_in.mag_word[15:8],
                              i_in.mag_word[23:16], i_in.mag_word[31:24]};
        n_front.pass.recno = i_in.record_number;
        n_front.pass.neg   = w_mag_u[31];
        n_front.mabs       = w_mag_u[31] ? (32'd0 - w_mag_u) : w_mag_u;

        // A negative coordinate lies below every lower bound and every upper bound.
        w_ra_ge  = !n_front.pass.ra_u[31] && (n_front.pass.ra_u >= {5'd0, i_cfg.ra_start});
        w_ra_le  = n_front.pass.ra_u[31] || (n_front.pass.ra_u <= {5'd0, i_cfg.ra_end});
        w_spd_ok = !n_front.pass.spd_u[31]
                   && (n_front.pass.spd_u >= {6'd0, i_cfg.spd_start})
                   && (n_front.pass.spd_u <= {6'd0, i_cfg.spd_end});
        n_front.pass.win_ok = w_spd_ok && (i_cfg.ra_wraps ? (w_ra_ge || w_ra_le)
                                                          : (w_ra_ge && w_ra_le));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready) begin
            r_front <= n_front;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/srbf_digits.sv
`default_nettype none

module srbf_digits (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire srbf_pkg::t_front  i_front,
    output logic                   o_ready,
    output logic                   o_valid,
    output srbf_pkg::t_digit       o_digit,
    input  wire logic              i_ready
);

    localparam int unsigned SH = srbf_pkg::DIV_SHIFT;

    // Stage one: magnitude times the reciprocal of a thousand.
    logic             r_v1;
    srbf_pkg::t_front r_f1;
    logic [60:0]      r_p1;
    // Stage two: low three digits, and the quotient times the reciprocal again.
    logic             r_v2;
    srbf_pkg::t_pass  r_pass2;
    logic [21:0]      r_q1;
    logic [9:0]       r_rrr2;
    logic [50:0]      r_p2;
    // Stage three: remaining digits.
    logic             r_v3;
    srbf_pkg::t_digit r_d3;

    logic             w_rdy1;
    logic             w_rdy2;
    logic             w_rdy3;
    logic [21:0]      n_q1;
    logic [31:0]      n_rdiff;
    logic [11:0]      n_q2;
    logic [21:0]      n_bdiff;
    logic [3:0]       n_qd;
    logic [11:0]      n_fdiff;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_digit = r_d3;

    always_comb begin
        n_q1    = r_p1[SH+21:SH];
        n_rdiff = r_f1.mabs - ({10'd0, n_q1} * 32'd1000);
        n_q2    = r_p2[SH+11:SH];
        n_bdiff = r_q1 - ({10'd0, n_q2} * 22'd1000);
        if (n_q2 >= 12'd2000) begin
            n_qd    = 4'd2;
            n_fdiff = n_q2 - 12'd2000;
        end else if (n_q2 >= 12'd1000) begin
            n_qd    = 4'd1;
            n_fdiff = n_q2 - 12'd1000;
        end else begin
            n_qd    = 4'd0;
            n_fdiff = n_q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_f1 <= i_front;
            r_p1 <= {29'd0, i_front.mabs} * {32'd0, srbf_pkg::DIV_MUL};
        end
        if (w_rdy2) begin
            r_pass2 <= r_f1.pass;
            r_q1    <= n_q1;
            r_rrr2  <= n_rdiff[9:0];
            r_p2    <= {29'd0, n_q1} * {22'd0, srbf_pkg::DIV_MUL};
        end
        if (w_rdy3) begin
            r_d3.pass <= r_pass2;
            r_d3.rrr  <= r_rrr2;
            r_d3.bbb  <= n_bdiff[9:0];
            r_d3.fff  <= n_fdiff[9:0];
            r_d3.qd   <= n_qd;
        end
    end

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_d3.rrr <= 10'd999 && r_d3.bbb <= 10'd999 && r_d3.fff <= 10'd999))
        else $error("digit out of decimal range");

    a_digits_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_d3.qd == 4'd2) |-> (r_d3.fff <= 10'd147))
        else $error("leading digit two with plate field above 147");

    a_digits_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_ready) |=> (r_v3 && $stable(r_d3)))
        else $error("stalled digit stage lost its word");

endmodule

`default_nettype wire

FILE: hw/rtl/star_record_box_filter_top.sv
`default_nettype none

// Channel | Direction | Payload
// i_in    | sink      | ra_word, spd_word, mag_word, record_number
// o_out   | source    | ra_cas, spd_cas, red_mag, blue_mag, act_match, quality_flag,
//         |           | plate_field, star_position, star_zone
// i_cfg   | sink      | index, data (always ready)
//
// One word is taken every cycle unless a full pipeline is stalled at the output; a kept star passes through
// the window compare stage, three digit stages around two reciprocal multiplications for the division
// by a thousand, and the output register.
// Synchronous active-low reset empties the pipeline and loads the default windows.
// Each stage holds its word when the one after it is full and stalled, so bubbles close up.
// Rejected stars are dropped at the output register.
module star_record_box_filter_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    srbf_in_if.sink     i_in,
    srbf_out_if.source  o_out,
    srbf_cfg_if.sink    i_cfg
);

    srbf_pkg::t_cfg   w_cfg;
    logic             w_front_valid;
    srbf_pkg::t_front w_front;
    logic             w_digits_ready;
    logic             w_digit_valid;
    srbf_pkg::t_digit w_digit;
    logic             w_out_ready;
    logic [9:0]       n_red;
    logic [9:0]       n_blue;
    logic             n_keep;

    logic             r_out_valid;
    srbf_pkg::t_digit r_out;
    logic [9:0]       r_red;
    logic [9:0]       r_blue;

    srbf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    srbf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .i_ready (w_digits_ready),
        .o_valid (w_front_valid),
        .o_front (w_front)
    );

    srbf_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .i_front (w_front),
        .o_ready (w_digits_ready),
        .o_valid (w_digit_valid),
        .o_digit (w_digit),
        .i_ready (w_out_ready)
    );

    assign w_out_ready = !r_out_valid || o_out.ready;

    always_comb begin
        n_red  = (w_digit.rrr == srbf_pkg::MAG_NONE) ? w_digit.bbb : w_digit.rrr;
        n_blue = (w_digit.bbb == 10'd0 && w_digit.fff == 10'd0) ? w_digit.rrr : w_digit.bbb;
        n_keep = w_digit.pass.win_ok && (n_red >= w_cfg.mag_low) && (n_red <= w_cfg.mag_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_digit_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_out  <= w_digit;
            r_red  <= n_red;
            r_blue <= n_blue;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.ra_cas        = $signed(r_out.pass.ra_u);
    assign o_out.spd_cas       = $signed(r_out.pass.spd_u);
    assign o_out.red_mag       = r_red;
    assign o_out.blue_mag      = r_blue;
    assign o_out.act_match     = r_out.pass.neg;
    assign o_out.quality_flag  = r_out.qd;
    assign o_out.plate_field   = r_out.fff;
    assign o_out.star_position = r_out.pass.recno;
    assign o_out.star_zone     = w_cfg.zone_id;

    a_top_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_valid && !o_out.ready && w_digit_valid && w_front_valid))
        else $error("input refused while the pipeline has room");

    a_top_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_out.pass.win_ok && r_red <= 10'd999))
        else $error("word outside the position windows delivered");

endmodule

`default_nettype wire

FILE: tb/srbf_checker.sv
`default_nettype none

module srbf_checker
    import srbf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    srbf_in_if          i_in,
    srbf_out_if         i_out,
    srbf_cfg_if         i_cfg,
    output int unsigned o_errors,
    output int unsigned o_pending
);

    typedef struct packed {
        logic signed [31:0] ra_cas;
        logic signed [31:0] spd_cas;
        logic        [9:0]  red_mag;
        logic        [9:0]  blue_mag;
        logic               act_match;
        logic        [3:0]  quality_flag;
        logic        [9:0]  plate_field;
        logic        [31:0] star_position;
        logic        [10:0] star_zone;
    } t_star_result;

    localparam t_cfg WINDOW_RST = '{
        ra_start:  '0,
        ra_end:    RA_END_RST,
        ra_wraps:  1'b0,
        spd_start: '0,
        spd_end:   SPD_END_RST,
        mag_low:   '0,
        mag_high:  MAG_HIGH_RST,
        zone_id:   '0
    };

    t_cfg         window = WINDOW_RST;
    t_star_result kept_stars[$];
    int unsigned  mismatches = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [31:0] from_big_endian(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Returns 1 when the record falls inside every window; star holds the decoded fields.
    function automatic bit filter_star(input logic [31:0] ra_w, spd_w, mag_w, recno,
                                       input t_cfg win, output t_star_result star);
        logic [31:0] ra_u, spd_u, mag_u, mabs;
        longint      ra_v, spd_v;
        logic [9:0]  rrr, bbb, fff, red;
        bit          ra_ok;
        ra_u  = from_big_endian(ra_w);
        spd_u = from_big_endian(spd_w);
        mag_u = from_big_endian(mag_w);
        ra_v  = longint'($signed(ra_u));
        spd_v = longint'($signed(spd_u));
        mabs  = mag_u[31] ? -mag_u : mag_u;
        rrr   = 10'(mabs % 1000);
        bbb   = 10'((mabs / 1000) % 1000);
        fff   = 10'((mabs / 1000000) % 1000);
        red   = (rrr == MAG_NONE) ? bbb : rrr;
        if (win.ra_wraps) begin
            ra_ok = (ra_v >= longint'(win.ra_start)) || (ra_v <= longint'(win.ra_end));
        end else begin
            ra_ok = (ra_v >= longint'(win.ra_start)) && (ra_v <= longint'(win.ra_end));
        end
        star.ra_cas        = ra_u;
        star.spd_cas       = spd_u;
        star.red_mag       = red;
        star.blue_mag      = (bbb == 0 && fff == 0) ? rrr : bbb;
        star.act_match     = mag_u[31];
        star.quality_flag  = 4'(mabs / 1000000000);
        star.plate_field   = fff;
        star.star_position = recno;
        star.star_zone     = win.zone_id;
        return ra_ok
            && spd_v >= longint'(win.spd_start) && spd_v <= longint'(win.spd_end)
            && red >= win.mag_low && red <= win.mag_high;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_star_result predicted;
        t_star_result want;
        t_star_result got;
        if (!i_rst_n) begin
            window = WINDOW_RST;
            kept_stars.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (filter_star(i_in.ra_word, i_in.spd_word, i_in.mag_word,
                                i_in.record_number, window, predicted)) begin
                    kept_stars.push_back(predicted);
                end
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.ra_cas, i_out.spd_cas, i_out.red_mag, i_out.blue_mag,
                        i_out.act_match, i_out.quality_flag, i_out.plate_field,
                        i_out.star_position, i_out.star_zone};
                if (kept_stars.size() == 0) begin
                    mismatches++;
                    $display("%0t: star expected none got position %0h ra %0h",
                             $time, got.star_position, got.ra_cas);
                end else begin
                    want = kept_stars.pop_front();
                    check_field("ra_cas", want.ra_cas, got.ra_cas);
                    check_field("spd_cas", want.spd_cas, got.spd_cas);
                    check_field("red_mag", want.red_mag, got.red_mag);
                    check_field("blue_mag", want.blue_mag, got.blue_mag);
                    check_field("act_match", want.act_match, got.act_match);
                    check_field("quality_flag", want.quality_flag, got.quality_flag);
                    check_field("plate_field", want.plate_field, got.plate_field);
                    check_field("star_position", want.star_position, got.star_position);
                    check_field("star_zone", want.star_zone, got.star_zone);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_RA_START:  window.ra_start  = i_cfg.data[26:0];
                    CFG_RA_END:    window.ra_end    = i_cfg.data[26:0];
                    CFG_RA_WRAPS:  window.ra_wraps  = i_cfg.data[0];
                    CFG_SPD_START: window.spd_start = i_cfg.data[25:0];
                    CFG_SPD_END:   window.spd_end   = i_cfg.data[25:0];
                    CFG_MAG_LOW:   window.mag_low   = i_cfg.data[9:0];
                    CFG_MAG_HIGH:  window.mag_high  = i_cfg.data[9:0];
                    CFG_ZONE_ID:   window.zone_id   = i_cfg.data[10:0];
                    default: ;
                endcase
            end
        end
        o_pending <= kept_stars.size();
        o_errors  <= mismatches;
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;
    import srbf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam logic [31:0] RA_SPAN     = 32'd129600000;
    localparam logic [31:0] SPD_SPAN    = 32'd64800000;

    logic        i_clk;
    logic        i_rst_n;
    bit          steady;
    int unsigned cycles = 0;
    int unsigned errors;
    int unsigned pending;

    // Windows as last written, so that random records can be aimed at them.
    logic [26:0] ra_lo  = '0;
    logic [26:0] ra_hi  = RA_END_RST;
    bit          ra_wrap = 1'b0;
    logic [25:0] spd_lo = '0;
    logic [25:0] spd_hi = SPD_END_RST;
    logic [9:0]  mag_lo = '0;
    logic [9:0]  mag_hi = MAG_HIGH_RST;

    srbf_in_if  in_ch();
    srbf_out_if out_ch();
    srbf_cfg_if cfg_ch();

    star_record_box_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    srbf_checker u_star_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= steady || ($urandom_range(99) >= 7);
        end
    end

    function automatic logic [31:0] to_big_endian(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Packed magnitude word QFFFBBBRRR with its sign, already in stored byte order.
    function automatic logic [31:0] pack_mag(input int unsigned q, fff, bbb, rrr,
                                             input bit neg);
        logic [31:0] mabs;
        mabs = q * 32'd1000000000 + fff * 32'd1000000 + bbb * 32'd1000 + rrr;
        return to_big_endian(neg ? -mabs : mabs);
    endfunction

    // Mostly inside the window, some at its edges, some anywhere in 32 bits.
    function automatic logic [31:0] pick_coord(input logic [31:0] lo, hi, span,
                                               input bit wraps);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8) return $urandom;
        if (sel < 20) begin
            case ($urandom_range(3))
                0: return lo - 1;
                1: return lo;
                2: return hi;
                default: return hi + 1;
            endcase
        end
        if (!wraps) return $urandom_range(hi, lo);
        if ($urandom_range(1)) return $urandom_range(span, lo);
        return $urandom_range(hi, 0);
    endfunction

    function automatic logic [31:0] pick_mag(input logic [9:0] lo, hi);
        int unsigned q, fff, bbb, rrr, sel;
        sel = $urandom_range(99);
        if (sel < 5) return $urandom;
        if (sel < 8) return to_big_endian(32'h80000000);
        q   = $urandom_range(2);
        fff = (q == 2) ? $urandom_range(146) : $urandom_range(999);
        bbb = $urandom_range(999);
        rrr = $urandom_range(hi, lo);
        if (rrr > 999) rrr = $urandom_range(999);
        if (sel < 20) begin
            // Red digits blank, so the blue digits stand in for red.
            bbb = rrr;
            rrr = 999;
        end else if (sel < 30) begin
            bbb = 0;
            fff = 0;
        end
        return pack_mag(q, fff, bbb, rrr, $urandom_range(1));
    endfunction

    task automatic send_star(input logic [31:0] ra_w, spd_w, mag_w, recno);
        while (!steady && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.ra_word       <= ra_w;
        in_ch.spd_word      <= spd_w;
        in_ch.mag_word      <= mag_w;
        in_ch.record_number <= recno;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random_stars(input int n);
        repeat (n) begin
            send_star(to_big_endian(pick_coord(ra_lo, ra_hi, RA_SPAN, ra_wrap)),
                      to_big_endian(pick_coord(spd_lo, spd_hi, SPD_SPAN, 1'b0)),
                      pick_mag(mag_lo, mag_hi), $urandom);
        end
    endtask

    // The sender holds off until every kept star has come out and the pipeline is empty.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Bits above each register's width carry noise; the block should drop them.
    task automatic set_windows(input logic [26:0] ra_s, ra_e, input bit wraps,
                               input logic [25:0] spd_s, spd_e,
                               input logic [9:0] m_lo, m_hi, input logic [10:0] zone);
        write_reg(CFG_RA_START, 32'(ra_s) | ($urandom << 27));
        write_reg(CFG_RA_END, 32'(ra_e) | ($urandom << 27));
        write_reg(CFG_RA_WRAPS, 32'(wraps) | ($urandom << 1));
        write_reg(CFG_SPD_START, 32'(spd_s) | ($urandom << 26));
        write_reg(CFG_SPD_END, 32'(spd_e) | ($urandom << 26));
        write_reg(CFG_MAG_LOW, 32'(m_lo) | ($urandom << 10));
        write_reg(CFG_MAG_HIGH, 32'(m_hi) | ($urandom << 10));
        write_reg(CFG_ZONE_ID, 32'(zone) | ($urandom << 11));
        cfg_ch.valid <= 1'b0;
        ra_lo   = ra_s;
        ra_hi   = ra_e;
        ra_wrap = wraps;
        spd_lo  = spd_s;
        spd_hi  = spd_e;
        mag_lo  = m_lo;
        mag_hi  = m_hi;
    endtask

    task automatic random_windows();
        logic [26:0] ra_a, ra_b;
        logic [25:0] spd_a, spd_b;
        logic [9:0]  mag_a, mag_b;
        bit          wraps;
        ra_a  = $urandom_range(RA_SPAN);
        ra_b  = $urandom_range(RA_SPAN);
        spd_a = $urandom_range(SPD_SPAN);
        spd_b = $urandom_range(SPD_SPAN);
        mag_a = $urandom_range(999);
        mag_b = $urandom_range(999);
        wraps = $urandom_range(1);
        if (!wraps && ra_a > ra_b) {ra_a, ra_b} = {ra_b, ra_a};
        if (spd_a > spd_b) {spd_a, spd_b} = {spd_b, spd_a};
        if (mag_a > mag_b) {mag_a, mag_b} = {mag_b, mag_a};
        set_windows(ra_a, ra_b, wraps, spd_a, spd_b, mag_a, mag_b, $urandom_range(1800));
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        steady              <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.ra_word       <= '0;
        in_ch.spd_word      <= '0;
        in_ch.mag_word      <= '0;
        in_ch.record_number <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_RA_START;
        cfg_ch.data         <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default windows: bounds, negative coordinates and the magnitude decoding rules.
        send_star(to_big_endian(0), to_big_endian(0), to_big_endian(0), 32'd0);
        send_star(to_big_endian(RA_SPAN), to_big_endian(SPD_SPAN),
                  pack_mag(0, 0, 0, 456, 0), 32'hFFFFFFFF);
        send_star(to_big_endian(RA_SPAN + 1), to_big_endian(100),
                  pack_mag(0, 12, 34, 56, 0), 32'd2);
        send_star(to_big_endian(100), to_big_endian(SPD_SPAN + 1),
                  pack_mag(0, 12, 34, 56, 0), 32'd3);
        send_star(to_big_endian(32'hFFFFFFFF), to_big_endian(5),
                  pack_mag(0, 1, 2, 3, 0), 32'd4);
        send_star(to_big_endian(7), to_big_endian(32'h80000000),
                  pack_mag(0, 1, 2, 3, 0), 32'd5);
        send_star(to_big_endian(1000), to_big_endian(1000),
                  to_big_endian(32'h80000000), 32'd6);
        send_star(to_big_endian(2000), to_big_endian(2000),
                  pack_mag(1, 234, 123, 999, 0), 32'd7);
        send_star(to_big_endian(3000), to_big_endian(3000),
                  pack_mag(0, 0, 999, 999, 1), 32'd8);
        send_star(to_big_endian(4000), to_big_endian(4000),
                  pack_mag(0, 5, 0, 321, 0), 32'd9);
        send_star(to_big_endian(5000), to_big_endian(5000),
                  to_big_endian(32'h7FFFFFFF), 32'd10);
        send_star(to_big_endian(6000), to_big_endian(6000),
                  pack_mag(2, 147, 483, 647, 1), 32'd11);
        send_star(to_big_endian(7000), to_big_endian(7000),
                  pack_mag(0, 1, 234, 567, 1), 32'd12);
        send_star(to_big_endian(8000), to_big_endian(8000), 32'hFFFFFFFF, 32'hAAAAAAAA);
        send_star(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h55555555);
        send_random_stars(150);
        settle();

        set_windows(27'd10000000, 27'd50000000, 1'b0, 26'd20000000, 26'd40000000,
                    10'd100, 10'd600, 11'd1800);
        send_random_stars(200);
        settle();

        // A stretch with neither side idling.
        steady <= 1'b1;
        set_windows(27'd100000000, 27'd20000000, 1'b1, '0, SPD_END_RST,
                    '0, MAG_HIGH_RST, 11'd900);
        send_random_stars(200);
        settle();
        steady <= 1'b0;

        set_windows('0, RA_END_RST, 1'b1, 26'd32000000, 26'd32000000,
                    10'd999, 10'd999, '0);
        send_random_stars(150);
        settle();

        // Inverted and out-of-range bounds: the windows are empty.
        set_windows('1, '0, 1'b0, '1, '1, '1, '0, '1);
        send_random_stars(100);
        settle();

        set_windows('1, '0, 1'b1, '0, '1, '0, '1, 11'd1);
        send_random_stars(150);
        settle();

        repeat (3) begin
            random_windows();
            send_random_stars(170);
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
